[hw/rtl/imat_pkg.sv]
// Shared types and constants for the integer matrix calculator.
package imat_pkg;

    // Operation codes
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_TRA  = 3'd3;
    localparam logic [2:0] OP_TRB  = 3'd4;

    // Register indexes
    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_OP   = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        S_LOAD = 4'b0001,
        S_READ = 4'b0010,
        S_MAC  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

endpackage

[hw/rtl/integer_matrix_add_sub_mul_transpose.sv]
// Integer matrix calculator: pairs of A/B elements stream in row-major order into two
// memories, one request per cycle while the block is in its load state. After the last pair,
// for a valid operation code, the block works row by row: it reads one operand pair per
// cycle, K*cols pairs per output row (K = cols for multiply, 1 otherwise), waits for the
// read and term registers to drain, and then streams the row out of a chain of MAX_DIM
// cells, one element per cycle while the receiver is ready. No new pair is accepted until the
// whole result has been handed to the output register. tlast marks the final element, tuser
// flags a non-square multiply or transpose, whose values are zero. Memories are not cleared
// after reset.
module integer_matrix_add_sub_mul_transpose import imat_pkg::*; #(
    parameter int MAX_DIM = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [3:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] a_value, [63:32] b_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] value, [34:32] out_row, [37:35] out_col
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // [0] shape_error
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = $clog2(MAX_DIM);

    logic [3:0]    r_rows, r_cols;
    logic [2:0]    r_op;
    logic [DW:0]   w_nr, w_nc, w_nr_m1, w_nc_m1;
    logic [6:0]    w_total;
    logic [31:0]   mem_a [DEPTH];
    logic [31:0]   mem_b [DEPTH];
    logic [31:0]   r_rd_a, r_rd_b;
    logic [AW-1:0] w_wr_addr, w_addr_a, w_addr_b;
    logic [AW-1:0] w_idx_rc, w_idx_rk, w_idx_kc, w_idx_cr;
    logic          w_load, w_load_done;
    logic [7:0]    w_cnt_next;
    t_state        r_state, n_state;
    logic [6:0]    r_cnt;
    logic [DW-1:0] r_row, r_col, r_k;
    logic          r_err, w_mul, w_issue;
    logic          w_last_k, w_last_col, w_last_row, w_emit_fire;
    logic          r_v1, r_first1, r_last1, r_v2, r_first2, r_last2;
    logic [31:0]   w_term, r_term, r_acc, w_sum;
    logic          w_push, w_shift;
    logic [31:0]   w_link [MAX_DIM+1];

    // Configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 4'd1;
            r_cols <= 4'd1;
            r_op   <= OP_ADD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ROWS: r_rows <= i_cfg_data;
                REG_COLS: r_cols <= i_cfg_data;
                REG_OP:   r_op   <= i_cfg_data[2:0];
                default:  ;
            endcase
        end
    end

    // Clamp dimensions
    always_comb begin
        w_nr = (r_rows == 4'd0) ? (DW+1)'(1) :
               (32'(r_rows) > MAX_DIM) ? (DW+1)'(MAX_DIM) : (DW+1)'(r_rows);
        w_nc = (r_cols == 4'd0) ? (DW+1)'(1) :
               (32'(r_cols) > MAX_DIM) ? (DW+1)'(MAX_DIM) : (DW+1)'(r_cols);
    end
    assign w_nr_m1 = w_nr - (DW+1)'(1);
    assign w_nc_m1 = w_nc - (DW+1)'(1);
    assign w_total = 7'(w_nr) * 7'(w_nc);

    // Load handshake
    assign s_axis_tready = (r_state == S_LOAD);
    assign w_load        = s_axis_tvalid && s_axis_tready;
    assign w_wr_addr     = AW'(r_cnt);
    assign w_cnt_next    = {1'b0, r_cnt} + 8'd1;
    assign w_load_done   = (w_cnt_next >= {1'b0, w_total});

    // Sequencer flags
    assign w_mul       = (r_op == OP_MUL);
    assign w_issue     = (r_state == S_READ);
    assign w_last_k    = !w_mul || ({1'b0, r_k} == w_nc_m1);
    assign w_last_col  = ({1'b0, r_col} == w_nc_m1);
    assign w_last_row  = ({1'b0, r_row} == w_nr_m1);
    assign w_emit_fire = (r_state == S_EMIT) && (!m_axis_tvalid || m_axis_tready);

    // Read addressing per operation
    assign w_idx_rc = AW'(r_row) * AW'(w_nc) + AW'(r_col);
    assign w_idx_rk = AW'(r_row) * AW'(w_nc) + AW'(r_k);
    assign w_idx_kc = AW'(r_k) * AW'(w_nc) + AW'(r_col);
    assign w_idx_cr = AW'(r_col) * AW'(w_nc) + AW'(r_row);

    always_comb begin
        w_addr_a = w_idx_rc;
        w_addr_b = w_idx_rc;
        unique case (r_op)
            OP_MUL: begin
                w_addr_a = w_idx_rk;
                w_addr_b = w_idx_kc;
            end
            OP_TRA, OP_TRB: begin
                w_addr_a = w_idx_cr;
                w_addr_b = w_idx_cr;
            end
            default: ;
        endcase
    end

    // Memories: write on load, registered read
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            mem_a[w_wr_addr] <= s_axis_tdata[31:0];
            mem_b[w_wr_addr] <= s_axis_tdata[63:32];
        end
        r_rd_a <= mem_a[w_addr_a];
        r_rd_b <= mem_b[w_addr_b];
    end

    // Form the term of the current element
    always_comb begin
        unique case (r_op)
            OP_ADD:  w_term = r_rd_a + r_rd_b;
            OP_SUB:  w_term = r_rd_a - r_rd_b;
            OP_MUL:  w_term = r_rd_a * r_rd_b;
            OP_TRB:  w_term = r_rd_b;
            default: w_term = r_rd_a;
        endcase
    end

    // Accumulate terms; push the finished element into the chain
    assign w_sum   = (r_first2 ? 32'd0 : r_acc) + r_term;
    assign w_push  = r_v2 && r_last2;
    assign w_shift = w_push || w_emit_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= w_issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first1 <= (r_k == '0);
        r_last1  <= w_last_k;
        r_first2 <= r_first1;
        r_last2  <= r_last1;
        r_term   <= w_term;
        if (r_v2) begin
            r_acc <= w_sum;
        end
    end

    // Chain of cells holding one result row, oldest element deepest
    assign w_link[0] = w_sum;
    genvar gi;
    generate
        for (gi = 0; gi < MAX_DIM; gi++) begin : g_cell
            imat_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_d     (w_link[gi]),
                .o_q     (w_link[gi+1])
            );
        end
    endgenerate

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: if (w_load && w_load_done && r_op <= OP_TRB) begin
                n_state = S_READ;
            end
            S_READ: if (w_last_k && w_last_col) n_state = S_MAC;
            S_MAC:  if (!r_v1) n_state = S_EMIT;
            S_EMIT: if (w_emit_fire && w_last_col) n_state = w_last_row ? S_LOAD : S_READ;
            default: n_state = S_LOAD;
        endcase
    end

    // Sequencer counters and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_LOAD;
            r_cnt         <= '0;
            r_row         <= '0;
            r_col         <= '0;
            r_k           <= '0;
            r_err         <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else begin
            r_state       <= n_state;
            m_axis_tvalid <= w_emit_fire || (m_axis_tvalid && !m_axis_tready);
            unique case (r_state)
                S_LOAD: if (w_load) begin
                    if (w_load_done) begin
                        r_cnt <= '0;
                        r_row <= '0;
                        r_col <= '0;
                        r_k   <= '0;
                        r_err <= (r_op >= OP_MUL) && (w_nr != w_nc);
                    end else begin
                        r_cnt <= w_cnt_next[6:0];
                    end
                end
                S_READ: begin
                    if (w_last_k) begin
                        r_k <= '0;
                        if (w_last_col) begin
                            r_col <= '0;
                        end else begin
                            r_col <= r_col + DW'(1);
                        end
                    end else begin
                        r_k <= r_k + DW'(1);
                    end
                end
                S_EMIT: if (w_emit_fire) begin
                    if (w_last_col) begin
                        r_col <= '0;
                        r_row <= r_row + DW'(1);
                    end else begin
                        r_col <= r_col + DW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Output register: take the deepest element of the row
    always_ff @(posedge i_clk) begin
        if (w_emit_fire) begin
            m_axis_tdata <= {2'b00, 3'(r_col), 3'(r_row), r_err ? 32'd0 : w_link[w_nc]};
            m_axis_tlast <= w_last_col && w_last_row;
            m_axis_tuser <= r_err;
        end
    end

endmodule

[hw/rtl/imat_cell.sv]
// One stage of the result chain: holds one element and hands it to the next stage on a shift.
module imat_cell (
    input  logic        i_clk,
    input  logic        i_shift,
    input  logic [31:0] i_d,
    output logic [31:0] o_q
);

    logic [31:0] r_q;

    // Take the neighbor's element on a shift, hold otherwise
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

[test/integer_matrix_add_sub_mul_transpose_test.sv]
// Testbench for the integer matrix calculator: streamed loads, predicted result matrices.
`timescale 1ns / 1ps

module integer_matrix_add_sub_mul_transpose_test import imat_pkg::*;;

    // Result element as predicted or observed
    typedef struct {
        logic [31:0] value;
        logic [2:0]  row;
        logic [2:0]  col;
        logic        last;
        logic        shape_err;
    } t_elem;

    // Predictor of the result matrices and queue of pending elements
    class matrix_scoreboard;
        logic [31:0] mat_a [64];
        logic [31:0] mat_b [64];
        logic [6:0]  load_cnt;
        logic [3:0]  rows_reg;
        logic [3:0]  cols_reg;
        logic [2:0]  op_reg;
        t_elem       pending [$];
        int          mismatches;

        function new();
            load_cnt   = '0;
            rows_reg   = 4'd1;
            cols_reg   = 4'd1;
            op_reg     = OP_ADD;
            mismatches = 0;
            foreach (mat_a[i]) begin
                mat_a[i] = '0;
                mat_b[i] = '0;
            end
        endfunction

        function int dim(logic [3:0] d);
            if (d == 0) return 1;
            if (d > 8) return 8;
            return d;
        endfunction

        function void write_reg(logic [1:0] idx, logic [3:0] data);
            case (idx)
                REG_ROWS: rows_reg = data;
                REG_COLS: cols_reg = data;
                REG_OP: op_reg = data[2:0];
                default: ;
            endcase
        endfunction

        // Store one pair; on a full load with a valid operation, build the whole result matrix
        function void note_pair(logic [31:0] a, logic [31:0] b);
            int nr, nc, idx;
            logic [31:0] v;
            logic err;
            t_elem e;
            nr = dim(rows_reg);
            nc = dim(cols_reg);
            mat_a[load_cnt[5:0]] = a;
            mat_b[load_cnt[5:0]] = b;
            load_cnt = load_cnt + 7'd1;
            if (load_cnt < nr * nc) return;
            load_cnt = '0;
            if (op_reg > OP_TRB) return;
            err = (op_reg >= OP_MUL) && (nr != nc);
            for (int r = 0; r < nr; r++) begin
                for (int c = 0; c < nc; c++) begin
                    v = '0;
                    if (!err) begin
                        idx = r * nc + c;
                        case (op_reg)
                            OP_ADD: v = mat_a[idx] + mat_b[idx];
                            OP_SUB: v = mat_a[idx] - mat_b[idx];
                            OP_MUL: begin
                                for (int k = 0; k < nc; k++)
                                    v = v + mat_a[r * nc + k] * mat_b[k * nc + c];
                            end
                            OP_TRA: v = mat_a[c * nc + r];
                            default: v = mat_b[c * nc + r];
                        endcase
                    end
                    e.value     = v;
                    e.row       = r[2:0];
                    e.col       = c[2:0];
                    e.last      = (r == nr - 1) && (c == nc - 1);
                    e.shape_err = err;
                    pending.push_back(e);
                end
            end
        endfunction

        function void check_elem(t_elem got);
            t_elem exp_e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value %h row %0d col %0d",
                             got.value, got.row, got.col);
                return;
            end
            exp_e = pending.pop_front();
            if (got.value !== exp_e.value || got.row !== exp_e.row || got.col !== exp_e.col ||
                got.last !== exp_e.last || got.shape_err !== exp_e.shape_err) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %h r%0d c%0d l%b e%b, got %h r%0d c%0d l%b e%b",
                             exp_e.value, exp_e.row, exp_e.col, exp_e.last, exp_e.shape_err,
                             got.value, got.row, got.col, got.last, got.shape_err);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [3:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // [31:0] a_value, [63:32] b_value
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [31:0] value, [34:32] out_row, [37:35] out_col
    logic        m_axis_tlast;
    logic        m_axis_tuser;   // [0] shape_error

    matrix_scoreboard sb;
    int  idle_cycles;
    bit  hold_off;
    bit  rx_idle_on;
    int  load_words;

    integer_matrix_add_sub_mul_transpose u_top (.*);

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return $urandom_range(0, 9);
            default: return $urandom();
        endcase
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [3:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // Wait until every pending result has drained, then let the pipeline settle
    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic send_pair(logic [31:0] a, logic [31:0] b, bit use_gaps);
        int g;
        g = use_gaps ? gap_len() : 0;
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_pair(a, b);
        load_words++;
    endtask

    task automatic configure(logic [3:0] r, logic [3:0] c, logic [2:0] op);
        s_axis_tvalid <= 1'b0;
        drain();
        write_reg(REG_ROWS, r);
        write_reg(REG_COLS, c);
        write_reg(REG_OP, op);
    endtask

    // Load one full matrix pair with the current shape
    task automatic send_matrix(bit use_gaps);
        int n;
        n = sb.dim(sb.rows_reg) * sb.dim(sb.cols_reg);
        for (int i = 0; i < n; i++) send_pair(rand_word(), rand_word(), use_gaps);
    endtask

    // Receiver: random stalls, or a long hold-off on request
    always @(posedge i_clk) begin
        t_elem e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            e.value     = m_axis_tdata[31:0];
            e.row       = m_axis_tdata[34:32];
            e.col       = m_axis_tdata[37:35];
            e.last      = m_axis_tlast;
            e.shape_err = m_axis_tuser;
            sb.check_elem(e);
        end
    end

    initial begin
        int g;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                g = gap_len() + 1;
                m_axis_tready <= 1'b0;
                repeat (g) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any accepted request
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("integer_matrix_add_sub_mul_transpose_test NOT OK");
            $finish;
        end
    end

    initial begin
        logic [3:0] r, c;
        sb = new();
        idle_cycles   = 0;
        hold_off      = 1'b0;
        rx_idle_on    = 1'b0;
        load_words    = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset shape, extremes, every operation, shape errors, clamping
        send_pair(32'h7fff_ffff, 32'h0000_0001, 0);
        send_pair(32'h8000_0000, 32'hffff_ffff, 0);
        configure(4'd2, 4'd2, OP_SUB);
        send_pair(32'h8000_0000, 32'h0000_0001, 0);
        send_pair(32'h0000_0000, 32'h8000_0000, 0);
        send_pair(32'hffff_ffff, 32'h7fff_ffff, 0);
        send_pair(32'h0000_0005, 32'hffff_fffb, 0);
        configure(4'd2, 4'd2, OP_MUL);
        send_pair(32'h7fff_ffff, 32'h7fff_ffff, 0);
        send_pair(32'h8000_0000, 32'h0000_0002, 0);
        send_pair(32'hffff_ffff, 32'h8000_0000, 0);
        send_pair(32'h0000_0003, 32'hffff_ffff, 0);
        configure(4'd2, 4'd2, OP_TRA);
        send_matrix(0);
        configure(4'd2, 4'd2, OP_TRB);
        send_matrix(0);
        configure(4'd1, 4'd3, OP_MUL);
        send_matrix(0);
        configure(4'd3, 4'd1, OP_TRA);
        send_matrix(0);
        configure(4'd0, 4'd15, 3'd5);
        send_matrix(0);
        configure(4'd8, 4'd8, OP_ADD);
        send_matrix(0);

        // Random: mostly small shapes, a few full size, idling on both sides
        rx_idle_on = 1'b1;
        while (load_words < 240) begin
            if ($urandom_range(0, 7) == 0) begin
                r = 4'($urandom_range(0, 15));
                c = 4'($urandom_range(0, 15));
            end else begin
                r = 4'($urandom_range(1, 4));
                c = ($urandom_range(0, 1) != 0) ? r : 4'($urandom_range(1, 4));
            end
            configure(r, c, $urandom_range(0, 9) == 0 ? 3'($urandom_range(5, 7))
                                                      : 3'($urandom_range(0, 4)));
            if ($urandom_range(0, 5) == 0) hold_off = 1'b1;
            send_matrix(1);
            send_matrix($urandom_range(0, 1));
        end

        // Long receiver hold-off while a second matrix waits to stream in
        configure(4'd4, 4'd4, OP_MUL);
        hold_off = 1'b1;
        send_matrix(0);
        send_matrix(0);
        s_axis_tvalid <= 1'b0;
        drain();

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("integer_matrix_add_sub_mul_transpose_test OK");
        else
            $display("integer_matrix_add_sub_mul_transpose_test NOT OK");
        $finish;
    end

endmodule
